// File: hw/rtl/tidu_pkg.sv
// ----------------------------------------------------------------------------
// tidu_pkg: shared types and constants of the transmit I/Q deframer/upsampler
// Frame layout constants, group byte offsets and the pair record that
// travels from the deframer to the interpolator.
// ----------------------------------------------------------------------------
package tidu_pkg;

	// Frame layout in bytes.
	localparam int unsigned HEADER_BYTES = 16;
	localparam int unsigned SYNC_BYTES   = 8;
	localparam int unsigned GROUP_BYTES  = 8;

	// Width of the rate mode register and of the run counter.
	localparam int unsigned RATE_W = 2;
	localparam int unsigned RUN_W  = 3;

	// Byte offsets within one group (L1 L0 R1 R0 I1 I0 Q1 Q0).
	localparam logic [2:0] OFF_I_HI = 3'd4;
	localparam logic [2:0] OFF_I_LO = 3'd5;
	localparam logic [2:0] OFF_Q_HI = 3'd6;
	localparam logic [2:0] OFF_Q_LO = 3'd7;

	// One completed I/Q pair waiting for the interpolator.
	typedef struct packed {
		logic               vld;
		logic signed [15:0] i;
		logic signed [15:0] q;
	} pair_t;

endpackage

// File: hw/rtl/tidu_deframe.sv
// ----------------------------------------------------------------------------
// tidu_deframe: frame byte deframer
// Tracks the byte position in the frame, drops header, sync and audio bytes
// and assembles big-endian I/Q pairs into a one-entry pair register.
// ----------------------------------------------------------------------------
module tidu_deframe #(
	parameter int unsigned GROUPS_PER_FRAME = 126
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  logic [7:0]    data_byte,
	input  logic          frame_start,
	input  logic          load,
	output tidu_pkg::pair_t pair
);

	localparam int unsigned FIRST_GROUPS = GROUPS_PER_FRAME / 2;
	localparam int unsigned FRAME_BYTES  = tidu_pkg::HEADER_BYTES + tidu_pkg::SYNC_BYTES
		+ tidu_pkg::GROUP_BYTES * GROUPS_PER_FRAME;
	localparam int unsigned POS_W   = $clog2(FRAME_BYTES);
	localparam int unsigned GRP1_LO = tidu_pkg::HEADER_BYTES;
	localparam int unsigned GRP1_HI = GRP1_LO + tidu_pkg::GROUP_BYTES * FIRST_GROUPS;
	localparam int unsigned GRP2_LO = GRP1_HI + tidu_pkg::SYNC_BYTES;

	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] pos_cur;
	logic [POS_W-1:0] pos_nxt;
	logic             in_grp;
	logic             pair_done;
	logic [7:0]       i_hi_q;
	logic [15:0]      i_cur_q;
	logic [7:0]       q_hi_q;
	tidu_pkg::pair_t  pair_s1;

	// Position of the byte being taken and of the next one.
	always_comb begin
		pos_cur = frame_start ? '0 : pos_q;
		pos_nxt = (pos_cur == POS_W'(FRAME_BYTES - 1)) ? '0 : pos_cur + POS_W'(1);
		in_grp  = ((pos_cur >= POS_W'(GRP1_LO)) && (pos_cur < POS_W'(GRP1_HI)))
			|| (pos_cur >= POS_W'(GRP2_LO));
		pair_done = accept && in_grp && (pos_cur[2:0] == tidu_pkg::OFF_Q_LO);
	end

	// Byte capture and pair register. Group regions start on multiples of
	// eight, so the low position bits give the offset within the group.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			i_hi_q    <= '0;
			i_cur_q   <= '0;
			q_hi_q    <= '0;
			pair_s1   <= '0;
		end else begin
			if (load && !pair_done) begin
				pair_s1.vld <= 1'b0;
			end
			if (accept) begin
				pos_q <= pos_nxt;
				if (in_grp) begin
					unique case (pos_cur[2:0])
						tidu_pkg::OFF_I_HI: i_hi_q  <= data_byte;
						tidu_pkg::OFF_I_LO: i_cur_q <= {i_hi_q, data_byte};
						tidu_pkg::OFF_Q_HI: q_hi_q  <= data_byte;
						tidu_pkg::OFF_Q_LO: begin
							pair_s1.vld <= 1'b1;
							pair_s1.i   <= i_cur_q;
							pair_s1.q   <= {q_hi_q, data_byte};
						end
						default: ;
					endcase
				end
			end
		end
	end

	assign pair = pair_s1;

	// A pending pair is never overwritten before the interpolator takes it.
	a_pair_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pair_s1.vld && !load |=> pair_s1.vld && $stable(pair_s1.i) && $stable(pair_s1.q))
		else $error("pending pair changed before load");

	// Loading a pair with no new pair completing empties the register.
	a_pair_drain: assert property (@(posedge clk) disable iff (!arst_n)
		load && !accept |=> !pair_s1.vld)
		else $error("pair register not emptied on load");

endmodule

// File: hw/rtl/tidu_interp.sv
// ----------------------------------------------------------------------------
// tidu_interp: linear interpolation run generator
// Loads one pair, computes the per-step delta truncated toward zero, steps an
// accumulator into the result register, one result per cycle unless stalled.
// ----------------------------------------------------------------------------
module tidu_interp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tidu_pkg::pair_t               pair,
	input  logic [tidu_pkg::RATE_W-1:0]   rate_mode,
	output logic                          load,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [15:0]            i_out,
	output logic signed [15:0]            q_out,
	output logic                          run_last
);

	logic                        busy_q;
	logic [tidu_pkg::RUN_W-1:0]  rem_q;
	logic [15:0]                 acc_i_q;
	logic [15:0]                 acc_q_q;
	logic [15:0]                 dlt_i_q;
	logic [15:0]                 dlt_q_q;
	logic [15:0]                 cur_i_q;
	logic [15:0]                 cur_q_q;
	logic [15:0]                 prev_i_q;
	logic [15:0]                 prev_q_q;
	logic                        out_vld_q;
	logic [15:0]                 out_i_q;
	logic [15:0]                 out_q_q;
	logic                        out_last_q;

	logic                        out_free;
	logic                        emit;
	logic                        finish;
	logic [tidu_pkg::RUN_W-1:0]  n_m1;
	logic signed [16:0]          diff_i;
	logic signed [16:0]          diff_q;
	logic signed [16:0]          bias;
	logic signed [16:0]          dsum_i;
	logic signed [16:0]          dsum_q;
	logic [15:0]                 dlt_i;
	logic [15:0]                 dlt_q;

	// Run control: a new pair loads when idle or as a run shows its last result.
	always_comb begin
		out_free = !out_vld_q || !out_stall;
		emit     = busy_q && out_free;
		finish   = emit && (rem_q == '0);
		load     = pair.vld && (!busy_q || finish);
		n_m1     = tidu_pkg::RUN_W'((4'd1 << rate_mode) - 4'd1);
	end

	// Delta: difference shifted right by the rate mode, biased so that
	// negative values truncate toward zero.
	always_comb begin
		diff_i = {pair.i[15], pair.i} - {prev_i_q[15], prev_i_q};
		diff_q = {pair.q[15], pair.q} - {prev_q_q[15], prev_q_q};
		bias   = 17'(n_m1);
		dsum_i = diff_i[16] ? diff_i + bias : diff_i;
		dsum_q = diff_q[16] ? diff_q + bias : diff_q;
		dlt_i  = 16'(dsum_i >>> rate_mode);
		dlt_q  = 16'(dsum_q >>> rate_mode);
	end

	// Run state and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			rem_q      <= '0;
			acc_i_q    <= '0;
			acc_q_q    <= '0;
			dlt_i_q    <= '0;
			dlt_q_q    <= '0;
			cur_i_q    <= '0;
			cur_q_q    <= '0;
			prev_i_q   <= '0;
			prev_q_q   <= '0;
			out_vld_q  <= 1'b0;
			out_i_q    <= '0;
			out_q_q    <= '0;
			out_last_q <= 1'b0;
		end else begin
			if (emit) begin
				out_vld_q <= 1'b1;
				if (rem_q != '0) begin
					out_i_q    <= acc_i_q;
					out_q_q    <= acc_q_q;
					out_last_q <= 1'b0;
					acc_i_q    <= acc_i_q + dlt_i_q;
					acc_q_q    <= acc_q_q + dlt_q_q;
					rem_q      <= rem_q - tidu_pkg::RUN_W'(1);
				end else begin
					out_i_q    <= cur_i_q;
					out_q_q    <= cur_q_q;
					out_last_q <= 1'b1;
					if (!load) begin
						busy_q <= 1'b0;
					end
				end
			end else if (out_free) begin
				out_vld_q <= 1'b0;
			end
			if (load) begin
				busy_q   <= 1'b1;
				rem_q    <= n_m1;
				dlt_i_q  <= dlt_i;
				dlt_q_q  <= dlt_q;
				acc_i_q  <= prev_i_q + dlt_i;
				acc_q_q  <= prev_q_q + dlt_q;
				cur_i_q  <= pair.i;
				cur_q_q  <= pair.q;
				prev_i_q <= pair.i;
				prev_q_q <= pair.q;
			end
		end
	end

	assign out_valid = out_vld_q;
	assign i_out     = out_i_q;
	assign q_out     = out_q_q;
	assign run_last  = out_last_q;

	// An idle generator has no results left to give.
	a_idle_rem: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> rem_q == '0)
		else $error("run count nonzero while idle");

	// A load starts a run of the selected length.
	a_load_run: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> busy_q && rem_q == $past(n_m1))
		else $error("run not started on load");

	// An interpolated result is always followed by more of the same run.
	a_run_cont: assert property (@(posedge clk) disable iff (!arst_n)
		emit && rem_q != '0 |=> busy_q)
		else $error("run ended before its last result");

endmodule

// File: hw/rtl/tx_iq_deframe_upsampler.sv
// ----------------------------------------------------------------------------
// tx_iq_deframe_upsampler: transmit frame I/Q deframer and upsampler
// Takes frame bytes, extracts I/Q pairs and emits 1, 2, 4 or 8 linearly
// interpolated samples per pair.
//
//   Channel  Direction  Handshake             Payload
//   in       input      in_valid / in_stall   data_byte, frame_start
//   out      output     out_valid / out_stall i_out, q_out, run_last
//   cfg      input      cfg_valid / cfg_ready rate_mode
//
// One byte is taken every cycle in which in_valid is high and in_stall low.
// A completed pair gives 2^rate_mode results, one per cycle from the result
// register unless out_stall holds it; the first goes through the pair register
// and the run state, after the last result of any run still in progress.
// in_stall rises only when a completed pair waits for a run still in progress.
// Reset clears the frame position, previous pair and rate mode to zero.
// ----------------------------------------------------------------------------
module tx_iq_deframe_upsampler #(
	parameter int unsigned GROUPS_PER_FRAME = 126
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [7:0]                  data_byte,
	input  logic                        frame_start,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic signed [15:0]          i_out,
	output logic signed [15:0]          q_out,
	output logic                        run_last,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [tidu_pkg::RATE_W-1:0] rate_mode
);

	logic [tidu_pkg::RATE_W-1:0] rate_q;
	tidu_pkg::pair_t             pair;
	logic                        load;
	logic                        accept;

	// Configuration register, always ready.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= '0;
		end else if (cfg_valid) begin
			rate_q <= rate_mode;
		end
	end

	// Input handshake: hold off only while a pending pair cannot load.
	assign in_stall = pair.vld && !load;
	assign accept   = in_valid && !in_stall;

	tidu_deframe #(
		.GROUPS_PER_FRAME(GROUPS_PER_FRAME)
	) u_deframe (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.data_byte  (data_byte),
		.frame_start(frame_start),
		.load       (load),
		.pair       (pair)
	);

	tidu_interp u_interp (
		.clk       (clk),
		.arst_n    (arst_n),
		.pair      (pair),
		.rate_mode (rate_q),
		.load      (load),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.i_out     (i_out),
		.q_out     (q_out),
		.run_last  (run_last)
	);

endmodule
